// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// File: hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the page table range walker modules.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int PA_W            = 48;
    localparam int VA_W            = 32;
    localparam int ROOT_W          = 36;
    localparam int IDX_W           = 10;
    localparam int ENTRY_W         = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 36;
    localparam int OUT_TDATA_W     = 88;
    localparam int RES_QUEUE_DEPTH = 4;

    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_DIR  = 2'd1;
    localparam logic [1:0] LVL_LEAF = 2'd2;

    typedef enum logic [1:0] {
        IN_START = 2'd0,
        IN_ENTRY = 2'd1,
        IN_FAIL  = 2'd2
    } in_kind_t;

    typedef enum logic [1:0] {
        RES_READ = 2'd0,
        RES_MAP  = 2'd1,
        RES_DONE = 2'd2
    } res_kind_t;

    typedef enum logic [1:0] {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_4M = 2'd2
    } page_size_t;

    typedef enum logic [1:0] {
        CFG_PAE   = 2'd0,
        CFG_ROOT  = 2'd1,
        CFG_BEGIN = 2'd2,
        CFG_END   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        res_kind_t         kind;
        logic [PA_W-1:0]   phys;
        logic [VA_W-1:0]   virt;
        page_size_t        size;
        logic              error;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

// File: hw/rtl/ptw_core.sv
// ----------------------------------------------------------------------------
// ptw_core
// Walk state, configuration registers and single-pass step decode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptw_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             accept,
    input  logic [1:0]                       kind,
    input  logic [ptw_pkg::ENTRY_W-1:0]      entry_word,
    output ptw_pkg::push_t                   push
);

    localparam logic [1:0] TOP  = ptw_pkg::LVL_TOP;
    localparam logic [1:0] DIR  = ptw_pkg::LVL_DIR;
    localparam logic [1:0] LEAF = ptw_pkg::LVL_LEAF;

    function automatic logic [4:0] lvl_shift(input logic pae, input logic [1:0] lv);
        logic [4:0] s;
        if (pae)
            s = (lv == TOP) ? 5'd30 : ((lv == DIR) ? 5'd21 : 5'd12);
        else
            s = (lv == TOP) ? 5'd22 : 5'd12;
        return s;
    endfunction

    function automatic logic [9:0] lvl_max(input logic pae, input logic [1:0] lv);
        logic [9:0] m;
        if (pae)
            m = (lv == TOP) ? 10'd3 : 10'd511;
        else
            m = 10'd1023;
        return m;
    endfunction

    function automatic logic [9:0] va_idx(input logic pae, input logic [31:0] va,
                                          input logic [1:0] lv);
        logic [31:0] sh;
        sh = va >> lvl_shift(pae, lv);
        return sh[9:0] & lvl_max(pae, lv);
    endfunction

    function automatic logic pick_flag(input logic [2:0] f, input logic [1:0] lv);
        logic b;
        case (lv)
            2'd0:    b = f[0];
            2'd1:    b = f[1];
            2'd2:    b = f[2];
            default: b = 1'b0;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] put_flag(input logic [2:0] f, input logic [1:0] lv,
                                            input logic v);
        logic [2:0] r;
        r = f;
        case (lv)
            2'd0:    r[0] = v;
            2'd1:    r[1] = v;
            2'd2:    r[2] = v;
            default: r = f;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] first_idx(input logic pae, input logic [2:0] bf,
                                             input logic [31:0] va, input logic [1:0] lv);
        return pick_flag(bf, lv) ? va_idx(pae, va, lv) : 10'd0;
    endfunction

    function automatic logic [9:0] last_idx(input logic pae, input logic [2:0] ef,
                                            input logic [31:0] va, input logic [1:0] lv);
        return pick_flag(ef, lv) ? va_idx(pae, va, lv) : lvl_max(pae, lv);
    endfunction

    function automatic logic [9:0] get_idx(input logic [1:0] lv, input logic [9:0] t,
                                           input logic [9:0] m, input logic [9:0] l);
        return (lv == TOP) ? t : ((lv == DIR) ? m : l);
    endfunction

    function automatic logic [1:0] cur_level(input logic pae, input logic [1:0] wl);
        logic [1:0] lv;
        lv = wl;
        if (lv == 2'd3)
            lv = LEAF;
        if (!pae && lv == DIR)
            lv = LEAF;
        return lv;
    endfunction

    function automatic logic [1:0] parent_of(input logic pae, input logic [1:0] lv);
        return (pae && lv != TOP) ? lv - 2'd1 : TOP;
    endfunction

    logic                         pae_reg;
    logic [ptw_pkg::ROOT_W-1:0]   root_reg;
    logic [31:0]                  begin_reg;
    logic [31:0]                  end_reg;

    logic        busy_reg,  busy_next;
    logic [1:0]  wl_reg,    wl_next;
    logic [9:0]  top_reg,   top_next;
    logic [9:0]  mid_reg,   mid_next;
    logic [9:0]  leaf_reg,  leaf_next;
    logic [47:0] dbase_reg, dbase_next;
    logic [47:0] lbase_reg, lbase_next;
    logic [2:0]  bf_reg,    bf_next;
    logic [2:0]  ef_reg,    ef_next;

    logic [63:0]       e;
    logic [1:0]        cl;
    logic [1:0]        child;
    logic [47:0]       child_base;
    logic              b_hit;
    logic              e_hit;
    logic              map_v;
    ptw_pkg::res_t     r_map;
    ptw_pkg::res_t     r_tail;
    logic              enter_v;
    logic [1:0]        enter_lv;
    logic [9:0]        ent_first;
    logic [9:0]        ent_last;
    logic              do_adv;
    logic              adv_done;
    logic [1:0]        adv_lv;
    logic [9:0]        adv_idx;
    logic              do_read;
    logic              do_fin;
    logic              fin_err;
    logic [1:0]        rd_lv;
    logic [9:0]        rd_idx;
    logic [47:0]       rd_base;
    logic [47:0]       rd_off;
    logic [31:0]       va_top;
    logic [31:0]       va_mid;
    logic [31:0]       va_leaf;

    always_comb
    begin
        va_top  = 32'({22'd0, top_reg & lvl_max(pae_reg, TOP)} << lvl_shift(pae_reg, TOP));
        va_mid  = pae_reg ? {2'd0, mid_reg[8:0], 21'd0} : 32'd0;
        va_leaf = {10'd0, leaf_reg & lvl_max(pae_reg, LEAF), 12'd0};
    end

    always_comb
    begin
        busy_next  = busy_reg;
        wl_next    = wl_reg;
        top_next   = top_reg;
        mid_next   = mid_reg;
        leaf_next  = leaf_reg;
        dbase_next = dbase_reg;
        lbase_next = lbase_reg;
        bf_next    = bf_reg;
        ef_next    = ef_reg;

        e          = pae_reg ? entry_word : {32'd0, entry_word[31:0]};
        cl         = cur_level(pae_reg, wl_reg);
        child      = pae_reg ? cl + 2'd1 : LEAF;
        child_base = pae_reg ? {e[47:12], 12'd0} : {16'd0, e[31:12], 12'd0};
        b_hit      = pick_flag(bf_reg, cl)
                     && get_idx(cl, top_reg, mid_reg, leaf_reg) == va_idx(pae_reg, begin_reg, cl);
        e_hit      = pick_flag(ef_reg, cl)
                     && get_idx(cl, top_reg, mid_reg, leaf_reg) == va_idx(pae_reg, end_reg, cl);

        map_v      = 1'b0;
        r_map      = '0;
        r_map.kind = ptw_pkg::RES_MAP;
        enter_v    = 1'b0;
        enter_lv   = TOP;
        ent_first  = 10'd0;
        ent_last   = 10'd0;
        do_adv     = 1'b0;
        adv_lv     = cl;
        adv_idx    = 10'd0;
        do_read    = 1'b0;
        do_fin     = 1'b0;
        fin_err    = 1'b0;

        if (accept)
        begin
            case (kind)
                ptw_pkg::IN_START:
                begin
                    busy_next  = 1'b1;
                    top_next   = 10'd0;
                    mid_next   = 10'd0;
                    leaf_next  = 10'd0;
                    dbase_next = 48'd0;
                    lbase_next = 48'd0;
                    bf_next    = 3'b001;
                    ef_next    = 3'b001;
                    enter_v    = 1'b1;
                    enter_lv   = TOP;
                end
                ptw_pkg::IN_ENTRY:
                begin
                    if (busy_reg)
                    begin
                        if (!e[0])
                        begin
                            do_adv = 1'b1;
                        end
                        else if (cl == LEAF)
                        begin
                            map_v      = 1'b1;
                            r_map.phys = child_base;
                            r_map.virt = va_top | va_mid | va_leaf;
                            r_map.size = ptw_pkg::SIZE_4K;
                            do_adv     = 1'b1;
                        end
                        else if (e[7] && (pae_reg ? (cl == DIR) : (cl == TOP)))
                        begin
                            map_v = 1'b1;
                            if (pae_reg)
                            begin
                                r_map.phys = {e[47:21], 21'd0};
                                r_map.virt = va_top | va_mid;
                                r_map.size = ptw_pkg::SIZE_2M;
                            end
                            else
                            begin
                                r_map.phys = {16'd0, e[31:22], 22'd0};
                                r_map.virt = va_top;
                                r_map.size = ptw_pkg::SIZE_4M;
                            end
                            do_adv = 1'b1;
                        end
                        else
                        begin
                            if (child == DIR)
                                dbase_next = child_base;
                            else
                                lbase_next = child_base;
                            bf_next  = put_flag(bf_reg, child, b_hit);
                            ef_next  = put_flag(ef_reg, child, e_hit);
                            enter_v  = 1'b1;
                            enter_lv = child;
                        end
                    end
                end
                ptw_pkg::IN_FAIL:
                begin
                    if (busy_reg)
                    begin
                        do_fin  = 1'b1;
                        fin_err = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (enter_v)
        begin
            wl_next   = enter_lv;
            ent_first = first_idx(pae_reg, bf_next, begin_reg, enter_lv);
            ent_last  = last_idx(pae_reg, ef_next, end_reg, enter_lv);
            case (enter_lv)
                TOP:     top_next  = ent_first;
                DIR:     mid_next  = ent_first;
                default: leaf_next = ent_first;
            endcase
            if (ent_first > ent_last)
            begin
                if (enter_lv == TOP)
                begin
                    do_fin = 1'b1;
                end
                else
                begin
                    wl_next = parent_of(pae_reg, enter_lv);
                    adv_lv  = parent_of(pae_reg, enter_lv);
                    do_adv  = 1'b1;
                end
            end
            else
            begin
                do_read = 1'b1;
            end
        end

        adv_done = !do_adv;
        for (int i = 0; i < 3; i++)
        begin
            if (!adv_done)
            begin
                adv_idx = get_idx(adv_lv, top_next, mid_next, leaf_next);
                if (adv_idx < last_idx(pae_reg, ef_next, end_reg, adv_lv))
                begin
                    case (adv_lv)
                        TOP:     top_next  = adv_idx + 10'd1;
                        DIR:     mid_next  = adv_idx + 10'd1;
                        default: leaf_next = adv_idx + 10'd1;
                    endcase
                    wl_next  = adv_lv;
                    do_read  = 1'b1;
                    adv_done = 1'b1;
                end
                else if (adv_lv == TOP)
                begin
                    do_fin   = 1'b1;
                    adv_done = 1'b1;
                end
                else
                begin
                    adv_lv  = parent_of(pae_reg, adv_lv);
                    wl_next = adv_lv;
                end
            end
        end

        rd_lv   = cur_level(pae_reg, wl_next);
        rd_idx  = get_idx(rd_lv, top_next, mid_next, leaf_next) & lvl_max(pae_reg, rd_lv);
        rd_base = (rd_lv == TOP) ? {12'd0, root_reg}
                : ((rd_lv == DIR) ? dbase_next : lbase_next);
        rd_off  = pae_reg ? {35'd0, rd_idx, 3'd0} : {36'd0, rd_idx, 2'd0};

        r_tail      = '0;
        r_tail.last = 1'b1;
        if (do_fin)
        begin
            busy_next    = 1'b0;
            wl_next      = TOP;
            r_tail.kind  = ptw_pkg::RES_DONE;
            r_tail.error = fin_err;
        end
        else
        begin
            r_tail.kind = ptw_pkg::RES_READ;
            r_tail.phys = rd_base + rd_off;
        end

        push = '0;
        if (map_v)
        begin
            push.count  = 2'd2;
            push.first  = r_map;
            push.second = r_tail;
        end
        else if (do_fin || do_read)
        begin
            push.count = 2'd1;
            push.first = r_tail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pae_reg   <= 1'b0;
            root_reg  <= '0;
            begin_reg <= 32'd0;
            end_reg   <= 32'hffff_ffff;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ptw_pkg::CFG_PAE:   pae_reg   <= cfg_wdata[0];
                ptw_pkg::CFG_ROOT:  root_reg  <= cfg_wdata[ptw_pkg::ROOT_W-1:0];
                ptw_pkg::CFG_BEGIN: begin_reg <= cfg_wdata[31:0];
                ptw_pkg::CFG_END:   end_reg   <= cfg_wdata[31:0];
                default:            pae_reg   <= pae_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            wl_reg    <= TOP;
            top_reg   <= 10'd0;
            mid_reg   <= 10'd0;
            leaf_reg  <= 10'd0;
            dbase_reg <= 48'd0;
            lbase_reg <= 48'd0;
            bf_reg    <= 3'd0;
            ef_reg    <= 3'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            wl_reg    <= wl_next;
            top_reg   <= top_next;
            mid_reg   <= mid_next;
            leaf_reg  <= leaf_next;
            dbase_reg <= dbase_next;
            lbase_reg <= lbase_next;
            bf_reg    <= bf_next;
            ef_reg    <= ef_next;
        end
    end

    `CHK_IMPLY(a_idle_entry_silent, accept && !busy_reg && kind != ptw_pkg::IN_START, push.count == 2'd0)
    `CHK_IMPLY(a_pair_leads_with_map, push.count == 2'd2, push.first.kind == ptw_pkg::RES_MAP && !push.first.last && push.second.last)
    `CHK_NEXT(a_done_clears_busy, (push.count == 2'd1 && push.first.kind == ptw_pkg::RES_DONE) || (push.count == 2'd2 && push.second.kind == ptw_pkg::RES_DONE), !busy_reg && wl_reg == TOP)

endmodule

// File: hw/rtl/ptw_res_queue.sv
// ----------------------------------------------------------------------------
// ptw_res_queue
// Result queue: takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptw_res_queue #(
    parameter int DEPTH = ptw_pkg::RES_QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  ptw_pkg::push_t push,
    output logic           room,
    output ptw_pkg::res_t  head,
    output logic           head_valid,
    input  logic           head_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    ptw_pkg::res_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              pop;
    logic [PTR_W-1:0]  wr_second;

    assign pop        = head_valid && head_ready;
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[head_reg];
    assign room       = cnt_reg <= CNT_W'(DEPTH - 2);
    assign wr_second  = next_ptr(tail_reg);

    always_comb
    begin
        head_next = pop ? next_ptr(head_reg) : head_reg;
        case (push.count)
            2'd1:    tail_next = next_ptr(tail_reg);
            2'd2:    tail_next = next_ptr(wr_second);
            default: tail_next = tail_reg;
        endcase
        cnt_next = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[tail_reg] <= push.first;
        if (push.count == 2'd2)
            slot_reg[wr_second] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    `CHK_IMPLY(a_push_has_room, push.count != 2'd0, cnt_reg <= CNT_W'(DEPTH - 2))

endmodule

// File: hw/rtl/x86_page_table_range_walker_top.sv
// ----------------------------------------------------------------------------
// x86_page_table_range_walker_top
// Walks 32-bit x86 page tables (two-level or PAE) over a virtual range.
// ----------------------------------------------------------------------------
// Usage: program pae_enable, root_addr, range_begin and range_end through the
// cfg port while the walker is quiet. Send a start item on the slave stream
// (tuser kind 0); the walker answers with a read request carrying the entry
// address. Return each entry word as kind 1, or kind 2 if the read failed.
// Each input transfer yields zero, one or two results on the master stream:
// read request, page mapping (physical base, virtual base, size) or walk
// finished (error set after a failed read); tlast marks the final result of
// that input transfer.
// Results are registered in a 4-entry result queue before they leave. The
// decode takes one item per cycle while s_tready is high and items yield one
// result; results drain at one per cycle while m_tready is high, so a run of
// items that yield two results is held to the drain rate. s_tready is high
// while the queue holds at most two results; a stalled receiver backs up
// into the input once the queue fills.
// Reset clears the walk state, the queue and the registers to their defaults.
// ----------------------------------------------------------------------------
module x86_page_table_range_walker_top #(
    parameter int RES_DEPTH = ptw_pkg::RES_QUEUE_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ptw_pkg::ENTRY_W-1:0]        s_tdata,  // entry_word
    input  logic [1:0]                         s_tuser,  // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ptw_pkg::OUT_TDATA_W-1:0]    m_tdata,  // phys_addr, virt_addr, page_size, error
    output logic [1:0]                         m_tuser,  // result_kind
    output logic                               m_tlast
);

    ptw_pkg::push_t push;
    ptw_pkg::res_t  head;
    logic           room;
    logic           accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    ptw_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .kind       (s_tuser),
        .entry_word (s_tdata),
        .push       (push)
    );

    ptw_res_queue #(
        .DEPTH (RES_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head       (head),
        .head_valid (m_tvalid),
        .head_ready (m_tready)
    );

    assign m_tdata = {5'd0, head.error, head.size, head.virt, head.phys};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
